// ===== design/udof_pkg.sv =====
// Package for the ultrasonic distance outlier filter.
// Holds the word types, register indexes and conversion constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package udof_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int ECHO_W = 13;
    localparam int Q8_W = 16;
    localparam int CNT_W = 8;
    localparam int ALPHA_W = 9;
    localparam int CFG_IDX_W = 3;

    // Conversion scale: round(0.01715 * 2^(FRACTION_BITS + 10)).
    localparam longint CONV_SCALE_L =
        ((longint'(1715) << (FRACTION_BITS + 10)) + 64'sd50000) / 64'sd100000;
    localparam int SCALE_W = $clog2(CONV_SCALE_L + 1);
    localparam logic [SCALE_W-1:0] CONV_SCALE = SCALE_W'(CONV_SCALE_L);
    localparam int CONV_SHIFT = 10;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 9'd256;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 3'd6;

    // Register values after reset.
    localparam logic [Q8_W-1:0] RST_RANGE_LOW = 16'd512;
    localparam logic [Q8_W-1:0] RST_RANGE_HIGH = 16'd8256;
    localparam logic [Q8_W-1:0] RST_MAX_JUMP = 16'd1024;
    localparam logic [CNT_W-1:0] RST_ACCEPT_COUNT = 8'd4;
    localparam logic [ALPHA_W-1:0] RST_EMA_ALPHA = 9'd64;
    localparam logic [Q8_W-1:0] RST_INITIAL = 16'd2637;
    localparam logic [CNT_W-1:0] RST_LOST_LIMIT = 8'd8;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    typedef logic [Q8_W-1:0] t_q8;
    typedef t_q8 [2:0] t_window;

    typedef struct packed {
        logic [ECHO_W-1:0] echo_us;
        logic              restart;
    } t_in_word;

    typedef struct packed {
        t_q8              raw_q8;
        logic             in_range;
        logic             accepted;
        t_q8              filtered_q8;
        logic [CNT_W-1:0] held_count;
        logic [CNT_W-1:0] bad_count;
        logic             position_lost;
    } t_out_word;

    typedef struct packed {
        t_q8                range_low_q8;
        t_q8                range_high_q8;
        t_q8                max_jump_q8;
        logic [CNT_W-1:0]   accept_count;
        logic [ALPHA_W-1:0] ema_alpha_q8;
        t_q8                initial_q8;
        logic [CNT_W-1:0]   lost_limit;
    } t_cfg;

    // Converted sample handed from the first stage to the filter stage.
    typedef struct packed {
        t_q8  raw_q8;
        logic in_range;
        logic restart;
    } t_conv_word;

endpackage

`default_nettype wire

// ===== design/ultrasonic_distance_outlier_filter_core.sv =====
// Top level of the ultrasonic distance outlier filter: handshakes,
// configuration registers and the result register.
// Depends on udof_pkg, udof_conv and udof_filter.
//
//   Channel   Ports                                   Dir  Word
//   input     i_in_valid / o_in_ready / i_in_data     in   t_in_word
//   output    o_out_valid / i_out_ready / o_out_data  out  t_out_word
//   config    i_cfg_wr_en / i_cfg_index / i_cfg_data  in   16-bit write
//
// A word accepted on the input waits in the conversion register; the filter stage
// loads its result into the result register when that register is free.
// A word is taken every cycle unless the output stalls; one filter update per word.
// While a result waits, the conversion register still takes one more word.
// Reset is synchronous and active low; it loads the register defaults and
// the filter state with no further pass.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_distance_outlier_filter_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire udof_pkg::t_in_word                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output udof_pkg::t_out_word                      o_out_data,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [udof_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [udof_pkg::Q8_W-1:0]           i_cfg_data
);

    udof_pkg::t_cfg        r_cfg;
    udof_pkg::t_out_word   r_out;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  w_s1_valid;
    udof_pkg::t_conv_word  w_s1_word;
    udof_pkg::t_out_word   w_result;
    logic                  w_out_free;
    logic                  w_step;
    logic                  w_load;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step = w_s1_valid && w_out_free;
    assign o_in_ready = !w_s1_valid || w_out_free;
    assign w_load = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low_q8 <= udof_pkg::RST_RANGE_LOW;
            r_cfg.range_high_q8 <= udof_pkg::RST_RANGE_HIGH;
            r_cfg.max_jump_q8 <= udof_pkg::RST_MAX_JUMP;
            r_cfg.accept_count <= udof_pkg::RST_ACCEPT_COUNT;
            r_cfg.ema_alpha_q8 <= udof_pkg::RST_EMA_ALPHA;
            r_cfg.initial_q8 <= udof_pkg::RST_INITIAL;
            r_cfg.lost_limit <= udof_pkg::RST_LOST_LIMIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                udof_pkg::CFG_RANGE_LOW: r_cfg.range_low_q8 <= i_cfg_data;
                udof_pkg::CFG_RANGE_HIGH: r_cfg.range_high_q8 <= i_cfg_data;
                udof_pkg::CFG_MAX_JUMP: r_cfg.max_jump_q8 <= i_cfg_data;
                udof_pkg::CFG_ACCEPT_COUNT: begin
                    r_cfg.accept_count <= i_cfg_data[udof_pkg::CNT_W-1:0];
                end
                udof_pkg::CFG_EMA_ALPHA: begin
                    r_cfg.ema_alpha_q8 <= i_cfg_data[udof_pkg::ALPHA_W-1:0];
                end
                udof_pkg::CFG_INITIAL: r_cfg.initial_q8 <= i_cfg_data;
                udof_pkg::CFG_LOST_LIMIT: begin
                    r_cfg.lost_limit <= i_cfg_data[udof_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    udof_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_take  (w_step),
        .i_word  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_s1_valid),
        .o_word  (w_s1_word)
    );

    udof_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (w_s1_word),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_comb begin
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ===== design/udof_conv.sv =====
// First stage: echo width to Q8.8 distance and valid window check.
// Registers the converted word. Depends on udof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udof_conv (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic                i_take,
    input  wire udof_pkg::t_in_word  i_word,
    input  wire udof_pkg::t_cfg      i_cfg,
    output logic                     o_valid,
    output udof_pkg::t_conv_word     o_word
);

    localparam int PROD_W = udof_pkg::ECHO_W + udof_pkg::SCALE_W;

    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W-1:0]     w_shift;
    udof_pkg::t_q8         w_raw;
    udof_pkg::t_conv_word  n_word;
    udof_pkg::t_conv_word  r_word;
    logic                  r_valid;
    logic                  n_valid;

    assign w_prod = PROD_W'(i_word.echo_us) * PROD_W'(udof_pkg::CONV_SCALE);
    assign w_shift = w_prod >> udof_pkg::CONV_SHIFT;
    // Saturate when the shifted product spills past sixteen bits.
    assign w_raw = (|w_shift[PROD_W-1:udof_pkg::Q8_W]) ? '1 : w_shift[udof_pkg::Q8_W-1:0];

    always_comb begin
        n_word.restart = i_word.restart;
        if (i_word.restart) begin
            n_word.raw_q8 = '0;
            n_word.in_range = 1'b0;
        end else begin
            n_word.raw_q8 = w_raw;
            n_word.in_range = (i_word.echo_us != '0)
                && (w_raw >= i_cfg.range_low_q8)
                && (w_raw <= i_cfg.range_high_q8);
        end
    end

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== design/udof_smooth.sv =====
// Median of the window by fill count, then the EMA step with floor rounding.
// Pure combinational. Depends on udof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udof_smooth (
    input  wire udof_pkg::t_window                 i_win,
    input  wire logic [1:0]                        i_fill,
    input  wire logic                              i_seeded,
    input  wire udof_pkg::t_q8                     i_filtered,
    input  wire logic [udof_pkg::ALPHA_W-1:0]      i_alpha,
    output udof_pkg::t_q8                          o_filtered
);

    udof_pkg::t_q8                 w_a;
    udof_pkg::t_q8                 w_b;
    udof_pkg::t_q8                 w_c;
    udof_pkg::t_q8                 w_med;
    logic [udof_pkg::Q8_W:0]       w_pair;
    logic [udof_pkg::ALPHA_W-1:0]  w_al;
    logic signed [16:0]            w_diff;
    logic signed [9:0]             w_al_s;
    logic signed [26:0]            w_prod;
    logic signed [17:0]            w_delta;
    logic signed [17:0]            w_sum;

    assign w_a = i_win[0];
    assign w_b = i_win[1];
    assign w_c = i_win[2];
    assign w_pair = {1'b0, w_a} + {1'b0, w_b};

    always_comb begin
        case (i_fill)
            2'd0: w_med = i_filtered;
            2'd1: w_med = w_a;
            2'd2: w_med = w_pair[udof_pkg::Q8_W:1];
            default: begin
                if (((w_a <= w_b) && (w_b <= w_c)) || ((w_c <= w_b) && (w_b <= w_a))) begin
                    w_med = w_b;
                end else if (((w_b <= w_a) && (w_a <= w_c))
                             || ((w_c <= w_a) && (w_a <= w_b))) begin
                    w_med = w_a;
                end else begin
                    w_med = w_c;
                end
            end
        endcase
    end

    // filtered + floor(alpha * (median - filtered) / 256) equals the weighted sum.
    assign w_al = (i_alpha > udof_pkg::ALPHA_MAX) ? udof_pkg::ALPHA_MAX : i_alpha;
    assign w_al_s = $signed({1'b0, w_al});
    assign w_diff = $signed({1'b0, w_med}) - $signed({1'b0, i_filtered});
    assign w_prod = w_diff * w_al_s;
    assign w_delta = w_prod[25:8];
    assign w_sum = $signed({2'b00, i_filtered}) + w_delta;

    assign o_filtered = i_seeded ? w_sum[udof_pkg::Q8_W-1:0] : w_med;

endmodule

`default_nettype wire

// ===== design/udof_filter.sv =====
// Filter stage: outlier hold, median window, EMA state and the result word.
// State updates on each step. Depends on udof_pkg and udof_smooth.
`timescale 1ns / 1ps
`default_nettype none

module udof_filter (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire udof_pkg::t_conv_word  i_word,
    input  wire udof_pkg::t_cfg        i_cfg,
    output udof_pkg::t_out_word        o_result
);

    udof_pkg::t_window               r_win;
    logic [1:0]                      r_ws;
    logic [1:0]                      r_fill;
    logic                            r_seeded;
    udof_pkg::t_q8                   r_filtered;
    udof_pkg::t_q8                   r_pend;
    logic [udof_pkg::CNT_W-1:0]      r_pc;
    logic [udof_pkg::CNT_W-1:0]      r_ic;

    udof_pkg::t_window               n_win;
    logic [1:0]                      n_ws;
    logic [1:0]                      n_fill;
    logic                            n_seeded;
    udof_pkg::t_q8                   n_filtered;
    udof_pkg::t_q8                   n_pend;
    logic [udof_pkg::CNT_W-1:0]      n_pc;
    logic [udof_pkg::CNT_W-1:0]      n_ic;

    logic                            w_take;
    udof_pkg::t_q8                   w_value;
    udof_pkg::t_q8                   w_pend;
    logic [udof_pkg::CNT_W-1:0]      w_pc;
    logic [udof_pkg::CNT_W-1:0]      w_ic;
    logic [udof_pkg::CNT_W-1:0]      w_ic_inc;
    logic [udof_pkg::Q8_W:0]         w_avg;
    logic                            w_outlier;
    udof_pkg::t_window               w_win_wr;
    logic [1:0]                      w_fill_wr;
    udof_pkg::t_q8                   w_ema;

    function automatic udof_pkg::t_q8 absdiff(udof_pkg::t_q8 a, udof_pkg::t_q8 b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign w_ic_inc = (r_ic == udof_pkg::CNT_MAX) ? r_ic : r_ic + 1'b1;
    assign w_avg = {1'b0, r_pend} + {1'b0, i_word.raw_q8};
    assign w_outlier = r_seeded
        && (absdiff(i_word.raw_q8, r_filtered) > i_cfg.max_jump_q8);

    // Accept decision for a sample that is not a restart.
    always_comb begin
        w_take = 1'b0;
        w_value = i_word.raw_q8;
        w_pend = r_pend;
        w_pc = r_pc;
        w_ic = w_ic_inc;
        if (i_word.in_range) begin
            if (w_outlier) begin
                if ((r_pc == '0)
                    || (absdiff(i_word.raw_q8, r_pend) > i_cfg.max_jump_q8)) begin
                    w_pend = i_word.raw_q8;
                    w_pc = 8'd1;
                end else if (r_pc != udof_pkg::CNT_MAX) begin
                    w_pend = w_avg[udof_pkg::Q8_W:1];
                    w_pc = r_pc + 1'b1;
                end
                if (w_pc >= i_cfg.accept_count) begin
                    w_take = 1'b1;
                    w_value = w_pend;
                    w_pc = '0;
                end
            end else begin
                w_take = 1'b1;
                w_pc = '0;
            end
        end
        if (w_take) begin
            w_ic = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_win_wr[i] = (r_ws == 2'(i)) ? w_value : r_win[i];
        end
        w_fill_wr = (r_fill == 2'd3) ? r_fill : r_fill + 1'b1;
    end

    udof_smooth u_smooth (
        .i_win      (w_win_wr),
        .i_fill     (w_fill_wr),
        .i_seeded   (r_seeded),
        .i_filtered (r_filtered),
        .i_alpha    (i_cfg.ema_alpha_q8),
        .o_filtered (w_ema)
    );

    always_comb begin
        if (i_word.restart) begin
            n_win = {3{i_cfg.initial_q8}};
            n_ws = '0;
            n_fill = '0;
            n_seeded = 1'b0;
            n_filtered = i_cfg.initial_q8;
            n_pend = i_cfg.initial_q8;
            n_pc = '0;
            n_ic = '0;
        end else if (w_take) begin
            n_win = w_win_wr;
            n_ws = (r_ws == 2'd2) ? 2'd0 : r_ws + 1'b1;
            n_fill = w_fill_wr;
            n_seeded = 1'b1;
            n_filtered = w_ema;
            n_pend = w_pend;
            n_pc = w_pc;
            n_ic = w_ic;
        end else begin
            n_win = r_win;
            n_ws = r_ws;
            n_fill = r_fill;
            n_seeded = r_seeded;
            n_filtered = r_filtered;
            n_pend = w_pend;
            n_pc = w_pc;
            n_ic = w_ic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= {3{udof_pkg::RST_INITIAL}};
            r_ws <= '0;
            r_fill <= '0;
            r_seeded <= 1'b0;
            r_filtered <= udof_pkg::RST_INITIAL;
            r_pend <= udof_pkg::RST_INITIAL;
            r_pc <= '0;
            r_ic <= '0;
        end else if (i_step) begin
            r_win <= n_win;
            r_ws <= n_ws;
            r_fill <= n_fill;
            r_seeded <= n_seeded;
            r_filtered <= n_filtered;
            r_pend <= n_pend;
            r_pc <= n_pc;
            r_ic <= n_ic;
        end
    end

    always_comb begin
        o_result.raw_q8 = i_word.raw_q8;
        o_result.in_range = i_word.in_range;
        o_result.accepted = w_take && !i_word.restart;
        o_result.filtered_q8 = n_filtered;
        o_result.held_count = n_pc;
        o_result.bad_count = n_ic;
        o_result.position_lost = (n_ic >= i_cfg.lost_limit);
    end

    // The ring pointer and fill count stay in their legal ranges.
    a_ring_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ws != 2'd3) && ((r_fill == 2'd0) || (r_ws != 2'd0) || (r_fill == 2'd3)))
        else $error("udof_filter: ring pointer out of step with fill count");

    // The filter is seeded exactly when the window holds at least one value.
    a_seed_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeded == (r_fill != 2'd0))
        else $error("udof_filter: seeded flag disagrees with fill count");

    // An accepted value clears the bad sample count and the hold.
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.accepted) |=> ((r_ic == '0) && (r_pc == '0)))
        else $error("udof_filter: counts not cleared after accept");

    // A restart leaves the filter empty and unseeded.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_word.restart) |=> (!r_seeded && (r_fill == '0) && (r_ws == '0)))
        else $error("udof_filter: restart did not empty the window");

endmodule

`default_nettype wire
